>>> design/fcft_pkg.sv
package fcft_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 64;
   localparam int NUM_TABLES = 4;

   localparam int REQ_TDATA_W = 152;
   localparam int RSP_TDATA_W = 64;
   localparam int VLAN_W = 12;
   localparam int MAC_W = 48;

   typedef enum logic [1:0] {
      CMD_LOOKUP    = 2'd0,
      CMD_ADD       = 2'd1,
      CMD_FLUSH_DIP = 2'd2,
      CMD_FLUSH_ALL = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_MISS    = 3'd0,
      STAT_HIT     = 3'd1,
      STAT_ADDED   = 3'd2,
      STAT_PRESENT = 3'd3,
      STAT_FLUSHED = 3'd4
   } status_type;

   localparam logic [1:0] PROTO_UDP = 2'd0;
   localparam logic [1:0] PROTO_TCP = 2'd1;

   localparam logic [1:0] CSR_ENABLE   = 2'd0;
   localparam logic [1:0] CSR_WAN_VLAN = 2'd1;
   localparam logic [1:0] CSR_LAN_VLAN = 2'd2;

   typedef enum logic [1:0] {
      PLAN_RESP  = 2'd0,
      PLAN_SCAN  = 2'd1,
      PLAN_SWEEP = 2'd2
   } plan_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SWEEP,
      FSM_SCAN,
      FSM_TAIL,
      FSM_COMMIT,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic valid;
      logic [31:0] age;
      logic [31:0] ports;
      logic [31:0] dip;
      logic [31:0] sip;
   } entry_type;

   typedef struct packed {
      logic load;
      logic sweep_start;
      logic sweep_step;
      logic init_step;
      logic scan_step;
      logic commit;
      logic respond;
   } ctrl_type;

   typedef struct packed {
      logic cnt_last;
      plan_type plan;
      logic clear_pending;
      logic out_busy;
   } stat_type;

endpackage

>>> design/fcft_ram.sv
module fcft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/fcft_datapath.sv
module fcft_datapath
   import fcft_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT,
   localparam int NUM_SLOTS = NUM_TABLES * MAX_ENTRIES,
   localparam int SLOT_W = $clog2(NUM_SLOTS),
   localparam int FILL_W = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [VLAN_W-1:0]      csr_data,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [2:0]             rsp_tuser,
   input  ctrl_type               ctrl,
   output stat_type               stat
);

   // Live request fields.
   logic        q_iport;
   logic [1:0]  q_proto;
   logic        q_syn;
   logic [1:0]  q_cmd;
   assign q_iport = req_tdata[0];
   assign q_proto = req_tdata[2:1];
   assign q_syn   = req_tdata[3];
   assign q_cmd   = req_tuser;

   // Configuration.
   logic              enable_ff;
   logic [VLAN_W-1:0] wan_vlan_ff, lan_vlan_ff;
   logic              pend_ff;

   // Latched request.
   cmd_type     cmd_ff;
   plan_type    plan_ff;
   logic        iport_ff;
   logic [1:0]  tbl_ff;
   logic [31:0] sip_ff, dip_ff, ports_ff;
   logic [MAC_W-1:0] mac_ff;
   logic        given_ff;

   // Scan counter.
   logic [SLOT_W-1:0] cnt_ff, base_ff, addr;
   logic [SLOT_W:0]   len_ff;

   // Second scan stage.
   logic              v1_ff;
   logic [SLOT_W-1:0] idx1_ff, addr1_ff;

   logic              found_ff;
   logic [MAC_W-1:0]  hit_mac_ff;
   logic              free_found_ff;
   logic [SLOT_W-1:0] free_addr_ff;
   logic              old_found_ff;
   logic [SLOT_W-1:0] old_addr_ff;
   logic [31:0]       old_dist_ff;

   logic [FILL_W-1:0] fill_ff [NUM_TABLES];
   logic [31:0]       seq_ff;

   logic                   rsp_valid_ff;
   logic [2:0]             rsp_status_ff;
   logic [MAC_W-1:0]       rsp_mac_ff;
   logic                   rsp_port_ff;
   logic [VLAN_W-1:0]      rsp_vlan_ff;
   logic [2:0]             res_status_ff;
   logic [MAC_W-1:0]       res_mac_ff;
   logic                   res_port_ff;
   logic [VLAN_W-1:0]      res_vlan_ff;

   // Memories.
   logic                    ent_we, mac_we;
   logic [SLOT_W-1:0]       wr_addr;
   entry_type               ent_wdata, ent_rd;
   logic [MAC_W-1:0]        mac_wdata, mac_rd;

   fcft_ram #(.WIDTH($bits(entry_type)), .DEPTH(NUM_SLOTS)) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (wr_addr),
      .wr_data (ent_wdata),
      .rd_en   (ctrl.scan_step),
      .rd_addr (addr),
      .rd_data (ent_rd)
   );

   fcft_ram #(.WIDTH(MAC_W), .DEPTH(NUM_SLOTS)) u_mac_ram (
      .clock   (clock),
      .wr_en   (mac_we),
      .wr_addr (wr_addr),
      .wr_data (mac_wdata),
      .rd_en   (ctrl.scan_step),
      .rd_addr (addr),
      .rd_data (mac_rd)
   );

   assign addr = base_ff + cnt_ff;

   // Plan for the live request.
   plan_type plan_live;
   always_comb begin
      plan_live = PLAN_RESP;
      if (enable_ff) begin
         case (q_cmd)
            CMD_LOOKUP:    plan_live = (q_proto inside {PROTO_UDP, PROTO_TCP}) ? PLAN_SCAN
                                                                                : PLAN_RESP;
            CMD_ADD:       plan_live = (q_proto == PROTO_UDP ||
                                        (q_proto == PROTO_TCP && q_syn)) ? PLAN_SCAN
                                                                           : PLAN_RESP;
            CMD_FLUSH_DIP: plan_live = PLAN_SCAN;
            default:       plan_live = PLAN_SWEEP;
         endcase
      end
   end

   // Second stage compare.
   logic        key_eq, match, dip_hit;
   logic [31:0] age_gap;
   logic [1:0]  tbl1;
   always_comb begin
      key_eq  = (ent_rd.sip == sip_ff) && (ent_rd.dip == dip_ff) && (ent_rd.ports == ports_ff);
      match   = v1_ff && ent_rd.valid && key_eq;
      dip_hit = v1_ff && ent_rd.valid && (ent_rd.dip == dip_ff) && (cmd_ff == CMD_FLUSH_DIP);
      age_gap = seq_ff - ent_rd.age;
      tbl1    = {iport_ff, (idx1_ff >= SLOT_W'(MAX_ENTRIES))};
   end

   logic              add_write;
   logic [SLOT_W-1:0] add_slot;
   assign add_write = ctrl.commit && (plan_ff == PLAN_SCAN) && (cmd_ff == CMD_ADD) && !found_ff;
   assign add_slot  = free_found_ff ? free_addr_ff : old_addr_ff;

   always_comb begin
      ent_we    = 1'b0;
      mac_we    = 1'b0;
      wr_addr   = addr;
      ent_wdata = '0;
      mac_wdata = '0;
      if (ctrl.init_step) begin
         ent_we = 1'b1;
         mac_we = 1'b1;
      end else if (ctrl.sweep_step) begin
         ent_we = 1'b1;
      end else if (dip_hit) begin
         ent_we          = 1'b1;
         wr_addr         = addr1_ff;
         ent_wdata       = ent_rd;
         ent_wdata.valid = 1'b0;
      end else if (add_write) begin
         ent_we          = 1'b1;
         mac_we          = given_ff;
         wr_addr         = add_slot;
         ent_wdata.valid = 1'b1;
         ent_wdata.age   = seq_ff;
         ent_wdata.ports = ports_ff;
         ent_wdata.dip   = dip_ff;
         ent_wdata.sip   = sip_ff;
         mac_wdata       = mac_ff;
      end
   end

   // Configuration, counter and table bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         wan_vlan_ff <= '0;
         lan_vlan_ff <= '0;
         pend_ff     <= 1'b0;
         cnt_ff      <= '0;
         base_ff     <= '0;
         len_ff      <= (SLOT_W+1)'(NUM_SLOTS);
         v1_ff       <= 1'b0;
         seq_ff      <= '0;
         for (int i = 0; i < NUM_TABLES; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         v1_ff <= ctrl.scan_step;
         if (csr_valid) begin
            case (csr_index)
               CSR_ENABLE: begin
                  if (enable_ff && !csr_data[0]) begin
                     pend_ff <= 1'b1;
                     for (int i = 0; i < NUM_TABLES; i++) begin
                        fill_ff[i] <= '0;
                     end
                  end
                  enable_ff <= csr_data[0];
               end
               CSR_WAN_VLAN: wan_vlan_ff <= csr_data;
               CSR_LAN_VLAN: lan_vlan_ff <= csr_data;
               default: ;
            endcase
         end
         if (ctrl.sweep_start) begin
            pend_ff <= 1'b0;
            cnt_ff  <= '0;
            base_ff <= '0;
            len_ff  <= (SLOT_W+1)'(NUM_SLOTS);
         end else if (ctrl.load) begin
            cnt_ff <= '0;
            case (q_cmd)
               CMD_FLUSH_DIP: begin
                  base_ff <= SLOT_W'(int'(q_iport) * 2 * MAX_ENTRIES);
                  len_ff  <= (SLOT_W+1)'(2 * MAX_ENTRIES);
               end
               CMD_FLUSH_ALL: begin
                  base_ff <= '0;
                  len_ff  <= (SLOT_W+1)'(NUM_SLOTS);
               end
               default: begin
                  base_ff <= SLOT_W'(int'({q_iport, (q_proto == PROTO_TCP)}) * MAX_ENTRIES);
                  len_ff  <= (SLOT_W+1)'(MAX_ENTRIES);
               end
            endcase
         end else if (ctrl.sweep_step || ctrl.init_step || ctrl.scan_step) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (dip_hit && fill_ff[tbl1] != '0) begin
            fill_ff[tbl1] <= fill_ff[tbl1] - 1'b1;
         end
         if (add_write) begin
            seq_ff <= seq_ff + 1'b1;
            if (free_found_ff) begin
               fill_ff[tbl_ff] <= fill_ff[tbl_ff] + 1'b1;
            end
         end
         if (ctrl.commit && plan_ff == PLAN_SWEEP) begin
            for (int i = 0; i < NUM_TABLES; i++) begin
               fill_ff[i] <= '0;
            end
         end
      end
   end

   // Request latch and scan results.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff        <= cmd_type'(q_cmd);
         plan_ff       <= plan_live;
         iport_ff      <= q_iport;
         tbl_ff        <= {q_iport, (q_proto == PROTO_TCP)};
         sip_ff        <= req_tdata[35:4];
         dip_ff        <= req_tdata[67:36];
         ports_ff      <= {req_tdata[99:84], req_tdata[83:68]};
         mac_ff        <= req_tdata[147:100];
         given_ff      <= req_tdata[148];
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         old_found_ff  <= 1'b0;
      end else if (v1_ff) begin
         if (match && !found_ff) begin
            found_ff   <= 1'b1;
            hit_mac_ff <= mac_rd;
         end
         if (!ent_rd.valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_addr_ff  <= addr1_ff;
         end
         if (ent_rd.valid && (!old_found_ff || age_gap > old_dist_ff)) begin
            old_found_ff <= 1'b1;
            old_addr_ff  <= addr1_ff;
            old_dist_ff  <= age_gap;
         end
      end
      idx1_ff  <= cnt_ff;
      addr1_ff <= addr;
   end

   // Result and output register.
   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         res_status_ff <= STAT_MISS;
         res_mac_ff    <= '0;
         res_port_ff   <= 1'b0;
         res_vlan_ff   <= '0;
         if (plan_ff != PLAN_RESP) begin
            case (cmd_ff)
               CMD_LOOKUP: begin
                  if (found_ff) begin
                     res_status_ff <= STAT_HIT;
                     res_mac_ff    <= hit_mac_ff;
                     res_port_ff   <= ~iport_ff;
                     res_vlan_ff   <= iport_ff ? wan_vlan_ff : lan_vlan_ff;
                  end
               end
               CMD_ADD: res_status_ff <= found_ff ? STAT_PRESENT : STAT_ADDED;
               default: res_status_ff <= STAT_FLUSHED;
            endcase
         end
      end
      if (ctrl.respond) begin
         rsp_status_ff <= res_status_ff;
         rsp_mac_ff    <= res_mac_ff;
         rsp_port_ff   <= res_port_ff;
         rsp_vlan_ff   <= res_vlan_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_vlan_ff, rsp_port_ff, rsp_mac_ff};

   always_comb begin
      stat.cnt_last      = ({1'b0, cnt_ff} == len_ff - 1'b1);
      stat.plan          = plan_live;
      stat.clear_pending = pend_ff;
      stat.out_busy      = rsp_valid_ff && !rsp_tready;
   end

endmodule

>>> design/fcft_ctrl.sv
module fcft_ctrl
   import fcft_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output ctrl_type ctrl
);

   fsm_type state_ff, state_in;
   logic    sweep_item_ff, sweep_item_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_CLEAR;
         sweep_item_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_item_ff <= sweep_item_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      sweep_item_in = sweep_item_ff;
      ctrl          = '0;
      req_tready    = 1'b0;
      case (state_ff)
         FSM_CLEAR: begin
            ctrl.init_step = 1'b1;
            if (stat.cnt_last) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (stat.clear_pending) begin
               ctrl.sweep_start = 1'b1;
               state_in         = FSM_SWEEP;
            end else begin
               req_tready = 1'b1;
               if (req_tvalid) begin
                  ctrl.load = 1'b1;
                  case (stat.plan)
                     PLAN_SCAN:  state_in = FSM_SCAN;
                     PLAN_SWEEP: begin
                        state_in      = FSM_SWEEP;
                        sweep_item_in = 1'b1;
                     end
                     default:    state_in = FSM_COMMIT;
                  endcase
               end
            end
         end
         FSM_SWEEP: begin
            ctrl.sweep_step = 1'b1;
            if (stat.cnt_last) begin
               state_in = sweep_item_ff ? FSM_COMMIT : FSM_IDLE;
            end
         end
         FSM_SCAN: begin
            ctrl.scan_step = 1'b1;
            if (stat.cnt_last) begin
               state_in = FSM_TAIL;
            end
         end
         FSM_TAIL: begin
            state_in = FSM_COMMIT;
         end
         FSM_COMMIT: begin
            ctrl.commit = 1'b1;
            state_in    = FSM_DONE;
         end
         FSM_DONE: begin
            if (!stat.out_busy) begin
               ctrl.respond  = 1'b1;
               sweep_item_in = 1'b0;
               state_in      = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

endmodule

>>> design/flow_cache_fifo_table_top.sv
// Exact-match flow cache with four tables (WAN/LAN by UDP/TCP), oldest-first
// replacement when a table is full.
// Request channel req_*: one transaction per command; req_tuser carries the
// command, req_tdata the flow key, MAC and flags. Response channel rsp_*:
// exactly one transaction per request, rsp_tuser holds the status.
// Configuration channel csr_*: index 0 enable, 1 WAN VLAN, 2 LAN VLAN; always ready.
// Items are handled one at a time, walking table memory one slot per cycle:
// lookup and add walk one table of MAX_ENTRIES slots, flush by destination IP
// both tables of the ingress port, flush all every table, and a miss (fast path
// off, other protocol, TCP add without SYN) walks no table at all.
// The entry and MAC memories have a single read port; that sets the walk rate.
// After reset a clearing pass over all 4 * MAX_ENTRIES slots runs before the
// first request is taken. Turning the fast path off starts a clearing pass over
// all slots before the next request is taken.
// The response sits in an output register; while the receiver stalls the next
// request is still accepted and worked on, and its result waits until the
// register is free.
module flow_cache_fifo_table_top
   import fcft_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // iport[0], protocol[2:1], syn_flag[3], src_ip[35:4], dst_ip[67:36],
   // src_port[83:68], dst_port[99:84], new_mac[147:100], mac_given[148], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // hit_mac[47:0], out_port[48], out_vlan[60:49], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]             rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [VLAN_W-1:0]      csr_data
);

   ctrl_type ctrl;
   stat_type stat;

   assign csr_ready = 1'b1;

   fcft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   fcft_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .ctrl       (ctrl),
      .stat       (stat)
   );

endmodule
